// File: design/mmc_clock_phase_delay_setting_unit_macros.svh
// assertion macros of the phase setting unit, used by its sequencer
// no dependencies; include with the bare file name
`ifndef MMC_CLOCK_PHASE_DELAY_SETTING_UNIT_MACROS_SVH
`define MMC_CLOCK_PHASE_DELAY_SETTING_UNIT_MACROS_SVH

// same-cycle implication
`define MCPDS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcpds assertion failed");

// next-cycle implication
`define MCPDS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcpds assertion failed");

`endif

// File: design/mcpds_pkg.sv
// types and constants of the memory card clock phase setting unit
// no dependencies; imported by every module of the unit
package mcpds_pkg;

    localparam int RATE_W  = 29;
    localparam int DEN_W   = 39;
    localparam int NUM_W   = 40;
    localparam int QUO_W   = 9;
    localparam int REQ_W   = 9;
    localparam int DEG_W   = 9;
    localparam int SET_W   = 11;
    localparam int DLY_W   = 8;
    localparam int CNT_W   = 6;

    localparam int DIV_STEPS = 40;
    localparam int RB_WAIT   = 7;

    localparam logic [RATE_W-1:0] RATE_RESET = 29'd50000000;
    localparam logic [NUM_W-1:0]  PS_PER_SEC = 40'd1000000000000;

    // 16 taps per cycle times 60 ps per element
    localparam int DELAY_DEN_MUL = 960;

    // reciprocal multipliers for constant divides
    localparam int Q45_MUL  = 1457;
    localparam int R10_MUL  = 820;
    localparam int Q90_MUL  = 729;
    localparam int Q22_MUL  = 187;
    localparam int MHZ_MUL  = 562949954;
    localparam int FINE_MUL = 27487791;
    localparam int Q360_MUL = 2913;
    localparam int DEG_FACTOR = 216;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_APPLY,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic div_init;
        logic div_step;
        logic apply;
        logic load_out;
    } t_cmd;

endpackage

// File: design/mcpds_div.sv
// restoring divider of the picosecond constant by the scaled clock rate
// one quotient bit per step, a sticky flag marks a quotient above nine bits; uses mcpds_pkg
module mcpds_div import mcpds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_init,
    input  logic             i_step,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_sat
);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [QUO_W-1:0] r_quo;
    logic             r_sat;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_sh   = {r_rem, r_num[NUM_W-1]};
        w_ge   = (w_sh >= {1'b0, i_den});
        w_diff = w_sh - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= '0;
            r_num <= PS_PER_SEC;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_sat <= r_sat | r_quo[QUO_W-1];
        end
    end

    assign o_quo = r_quo;
    assign o_sat = r_sat;

endmodule

// File: design/mcpds_ctrl.sv
// sequencer of the phase setting unit: handshakes, divide count, settle wait
// uses mcpds_pkg and the unit's assertion macros
`include "mmc_clock_phase_delay_setting_unit_macros.svh"

module mcpds_ctrl import mcpds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_action,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    w_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    if (i_in_action == ACT_SET) begin
                        w_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                w_cmd.apply = 1'b1;
                n_cnt       = '0;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (r_cnt == CNT_W'(RB_WAIT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    `MCPDS_ASSERT_NOW(a_load_into_free_slot, i_clk, i_rst_n,
        w_cmd.load_out, !r_out_valid || i_out_ready)
    `MCPDS_ASSERT_NEXT(a_set_starts_divide, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_in_action == ACT_SET),
        r_state == S_DIV && r_cnt == '0)
    `MCPDS_ASSERT_NEXT(a_divide_counts, i_clk, i_rst_n,
        r_state == S_DIV && r_cnt != CNT_W'(DIV_STEPS - 1),
        r_state == S_DIV && r_cnt == $past(r_cnt) + 1'b1)
    `MCPDS_ASSERT_NEXT(a_apply_then_wait, i_clk, i_rst_n,
        w_cmd.apply, r_state == S_WAIT && r_cnt == '0)

endmodule

// File: design/mcpds_dp.sv
// datapath of the phase setting unit: step split, delay scaling, read-back degrees
// uses mcpds_pkg and mcpds_div
module mcpds_dp import mcpds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_wdata,
    input  logic [REQ_W-1:0]  i_req_degrees,
    output logic [SET_W-1:0]  o_phase_setting,
    output logic [DLY_W-1:0]  o_delay_count,
    output logic [DEG_W-1:0]  o_phase_degrees
);

    logic [RATE_W-1:0] r_rate;
    logic [SET_W-1:0]  r_phase;
    logic [DEN_W-1:0]  r_den;

    logic [9:0]        r_d;
    logic [4:0]        r_q45;
    logic [9:0]        r_d2;
    logic [3:0]        r_q90;
    logic [2:0]        r_steps;
    logic [1:0]        r_quad;

    logic [9:0]        r_f;
    logic [24:0]       r_p;
    logic [11:0]       r_fine;
    logic [11:0]       r_sum;
    logic [3:0]        r_q360;
    logic [DEG_W-1:0]  r_deg;

    logic [SET_W-1:0]  r_out_set;
    logic [DEG_W-1:0]  r_out_deg;

    logic [QUO_W-1:0]  w_quo;
    logic              w_quo_sat;

    logic [21:0]       w_p45;
    logic [12:0]       w_r10;
    logic [17:0]       w_t10;
    logic [19:0]       w_p90;
    logic [9:0]        w_rem90;
    logic [14:0]       w_p22;
    logic [11:0]       w_prod;
    logic              w_clip;
    logic [DLY_W-1:0]  w_dn;
    logic [58:0]       w_pf;
    logic [16:0]       w_f216;
    logic [49:0]       w_pfine;
    logic [23:0]       w_p360;

    mcpds_div u_div (
        .i_clk  (i_clk),
        .i_init (i_cmd.div_init),
        .i_step (i_cmd.div_step),
        .i_den  (r_den),
        .o_quo  (w_quo),
        .o_sat  (w_quo_sat)
    );

    always_comb begin
        w_p45   = 22'({r_d, 1'b0}) * 22'(Q45_MUL);
        w_r10   = 13'(r_d) * 13'd10 - 13'(r_q45) * 13'd225;
        w_t10   = 18'(w_r10[7:0]) * 18'(R10_MUL);
        w_p90   = 20'(r_d2) * 20'(Q90_MUL);
        w_rem90 = r_d2 - 10'(r_q90) * 10'd90;
        w_p22   = 15'(w_rem90[6:0]) * 15'(Q22_MUL);
        w_prod  = 12'(w_quo) * 12'(r_steps);
        w_clip  = (w_quo_sat && (r_steps != 3'd0)) || (w_prod > 12'd255);
        w_dn    = w_clip ? 8'hFF : w_prod[DLY_W-1:0];
        w_pf    = 59'(r_rate) * 59'(MHZ_MUL);
        w_f216  = 17'(r_f) * 17'(DEG_FACTOR);
        w_pfine = 50'(r_p) * 50'(FINE_MUL);
        w_p360  = 24'(r_sum) * 24'(Q360_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RESET;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (i_cmd.apply) begin
                r_phase <= {(w_dn != '0), w_dn, r_quad};
            end
        end
    end

    // free-running stages, settled before the sequencer's commands capture them
    always_ff @(posedge i_clk) begin
        r_den   <= DEN_W'(r_rate) * DEN_W'(DELAY_DEN_MUL);
        if (i_cmd.load_in) begin
            r_d <= 10'(i_req_degrees) + 10'd1;
        end
        r_q45   <= w_p45[20:16];
        r_d2    <= r_d - 10'(w_t10[17:13]);
        r_q90   <= w_p90[19:16];
        r_steps <= w_p22[14:12];
        r_quad  <= r_q90[1:0];
        r_f     <= w_pf[58:49];
        r_p     <= 25'(w_f216) * 25'(r_phase[9:2]);
        r_fine  <= w_pfine[49:38];
        r_sum   <= 12'(r_phase[1:0]) * 12'd90 + (r_phase[SET_W-1] ? r_fine : 12'd0);
        r_q360  <= w_p360[23:20];
        r_deg   <= DEG_W'(r_sum - 12'(r_q360) * 12'd360);
        if (i_cmd.load_out) begin
            r_out_set <= r_phase;
            r_out_deg <= r_deg;
        end
    end

    assign o_phase_setting = r_out_set;
    assign o_delay_count   = r_out_set[9:2];
    assign o_phase_degrees = r_out_deg;

endmodule

// File: design/mmc_clock_phase_delay_setting_unit.sv
// memory card clock phase setting unit, top level; uses mcpds_pkg, mcpds_ctrl, mcpds_dp
// set beat: bit-serial rate divide, apply, settle wait; read beat: settle wait only
// throughput: one beat in flight; next beat taken once the result sits in the output register
// reset: synchronous active low, clears the sequencer, the output valid and the phase
// setting, and loads the clock rate register with 50 MHz
module mmc_clock_phase_delay_setting_unit import mcpds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [28:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // requested_degrees[8:0], zero pad
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // phase_setting[10:0], delay_count[18:11],
                                        // phase_degrees[27:19], zero pad
);

    t_cmd             w_cmd;
    logic [SET_W-1:0] w_phase_setting;
    logic [DLY_W-1:0] w_delay_count;
    logic [DEG_W-1:0] w_phase_degrees;

    mcpds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    mcpds_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_degrees   (s_axis_tdata[REQ_W-1:0]),
        .o_phase_setting (w_phase_setting),
        .o_delay_count   (w_delay_count),
        .o_phase_degrees (w_phase_degrees)
    );

    assign m_axis_tdata = {4'b0000, w_phase_degrees, w_delay_count, w_phase_setting};

endmodule
